FILE: rtl/gbfs_pkg.sv
// gbfs_pkg: shared types and constants of the graph search engine.
// No dependencies.
package gbfs_pkg;

    localparam int NODES_DEF = 64;
    localparam int CNT_W     = 7;
    localparam int EDGE_W    = 13;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_ADD_BOTH = 4'd1,
        OP_REM      = 4'd2,
        OP_REM_BOTH = 4'd3,
        OP_TEST     = 4'd4,
        OP_DIST     = 4'd5,
        OP_CONN     = 4'd6,
        OP_REACH    = 4'd7,
        OP_GROUPS   = 4'd8,
        OP_NEIGH    = 4'd9
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_WR_A,
        ST_RD_B,
        ST_WR_B,
        ST_LVL,
        ST_SCAN,
        ST_SCAN_W,
        ST_LVL_END,
        ST_GRP_NEXT,
        ST_OUT
    } state_t;

endpackage

FILE: rtl/gbfs_ram.sv
// gbfs_ram: generic single-port RAM with registered read.
// No dependencies.
module gbfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: rtl/graph_bfs_engine.sv
// graph_bfs_engine: adjacency-matrix graph store with breadth-first search.
// Depends on gbfs_pkg and gbfs_ram.
//
// channel   dir  width       fields, lowest bit first
// s_axis    in   24          opcode[3:0] node_a[9:4] node_b[15:10] max_distance[22:16]
// m_axis    out  88 + 2 + 1  tdata: distance[5:0] node_mask[69:6] edges_now[82:70]
//                            tuser: flag[0] error[1]; tlast: last
// cfg       in   7           node_count
//
// Every accepted word reads its node_a row in states RD_A and WR_A.
// One-way edge ops, test, neighbours and refused words then go straight to
// OUT; both-way edge ops pass through RD_B and WR_B for the node_b row.
// A search level (LVL, SCAN, SCAN_W, LVL_END) scans the n_eff valid rows one
// per cycle through the single RAM port, where n_eff = min(node_count, NODES).
// A search runs at most min(limit, n_eff) levels; groups passes through
// GRP_NEXT before each group's search. The RAM port is the limiting unit.
// After reset a clearing pass writes one row per cycle until all NODES rows
// are cleared; s_axis_tready is low meanwhile. The block takes one word at a
// time and is not ready until the last result word has been taken.
module graph_bfs_engine
    import gbfs_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // opcode, node_a, node_b, max_distance
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // distance, node_mask, edges_now
    output logic [1:0]  m_axis_tuser,  // flag, error
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);
    localparam int AW = $clog2(NODES);

    state_t st_reg, st_next;
    logic [CNT_W-1:0] ncfg_reg;
    logic [EDGE_W-1:0] edges_reg;
    logic [3:0] op_reg;
    logic [5:0] a_reg, b_reg;
    logic [6:0] lim_reg;
    logic [63:0] vis_reg, fr_reg, acc_reg, asg_reg, row_reg;
    logic [6:0] idx_reg, lvl_reg;
    logic       clr_reg;
    logic [AW:0] clr_cnt_reg;
    logic        o_flag_reg, o_err_reg, o_last_reg;
    logic [5:0]  o_dist_reg;
    logic [63:0] o_mask_reg;

    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [63:0] ram_wdata, ram_rdata;

    gbfs_ram #(.WIDTH(64), .DEPTH(NODES)) u_adj (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    logic [6:0] n_eff;
    logic [63:0] vmask;
    assign n_eff = (ncfg_reg < 7'(NODES)) ? ncfg_reg : 7'(NODES);
    assign vmask = (n_eff >= 7'd64) ? '1 : ((64'd1 << n_eff) - 64'd1);

    logic [3:0] i_op;
    logic [5:0] i_a, i_b;
    logic       acc_in;
    assign i_op = s_axis_tdata[3:0];
    assign i_a  = s_axis_tdata[9:4];
    assign i_b  = s_axis_tdata[15:10];
    assign acc_in = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (st_reg == ST_IDLE) && !clr_reg;

    logic [63:0] reached, newfr;
    assign reached = acc_reg & vmask;
    assign newfr   = reached & ~vis_reg;
    logic [6:0] lim_eff;
    assign lim_eff = (op_reg == OP_CONN)
                   ? ((edges_reg > 13'd127) ? 7'd127 : edges_reg[6:0])
                   : ((op_reg == OP_GROUPS) ? n_eff : lim_reg);
    logic search_done;
    assign search_done = (lvl_reg >= lim_eff) || (newfr == '0)
                      || ((op_reg == OP_DIST || op_reg == OP_CONN) && reached[b_reg]);

    // lowest ungrouped valid node
    logic [63:0] unas;
    logic [6:0]  first_un;
    logic        grp_more;
    assign unas = ~asg_reg & vmask;
    always_comb
    begin
        first_un = 7'd64;
        for (int k = 63; k >= 0; k--)
        begin
            if (unas[k]) first_un = 7'(k);
        end
    end
    assign grp_more = (first_un < 7'd64);

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:     if (acc_in) st_next = ST_RD_A;
            ST_RD_A:     st_next = ST_WR_A;
            ST_WR_A:
            begin
                if (o_err_reg || op_reg == OP_TEST || op_reg == OP_NEIGH)
                    st_next = ST_OUT;
                else if (op_reg == OP_ADD_BOTH || op_reg == OP_REM_BOTH)
                    st_next = ST_RD_B;
                else if (op_reg == OP_DIST || op_reg == OP_REACH)
                    st_next = (lim_reg == 7'd0) ? ST_OUT : ST_LVL;
                else if (op_reg == OP_CONN)
                    // direct edge, self query or empty graph: answered now
                    st_next = (ram_rdata[b_reg] || a_reg == b_reg || edges_reg == '0)
                            ? ST_OUT : ST_LVL;
                else if (op_reg == OP_GROUPS)
                    st_next = ST_GRP_NEXT;
                else
                    st_next = ST_OUT;
            end
            ST_RD_B:     st_next = ST_WR_B;
            ST_WR_B:     st_next = ST_OUT;
            ST_LVL:      st_next = ST_SCAN;
            ST_SCAN:     st_next = (idx_reg + 7'd1 >= n_eff) ? ST_SCAN_W : ST_SCAN;
            ST_SCAN_W:   st_next = ST_LVL_END;
            ST_LVL_END:  st_next = search_done ? ST_OUT : ST_LVL;
            ST_GRP_NEXT: st_next = grp_more ? ST_LVL : ST_OUT;
            ST_OUT:
            begin
                if (m_axis_tvalid && m_axis_tready)
                    st_next = (o_last_reg) ? ST_IDLE : ST_GRP_NEXT;
            end
            default:     st_next = ST_IDLE;
        endcase
    end

    // RAM port control
    always_comb
    begin
        ram_we = 1'b0;
        ram_addr = a_reg[AW-1:0];
        ram_wdata = row_reg;
        if (clr_reg)
        begin
            ram_we = 1'b1;
            ram_addr = clr_cnt_reg[AW-1:0];
            ram_wdata = '0;
        end
        else
        begin
            unique case (st_reg)
                ST_RD_A, ST_WR_A: ram_addr = a_reg[AW-1:0];
                ST_RD_B, ST_WR_B: ram_addr = b_reg[AW-1:0];
                ST_SCAN:          ram_addr = idx_reg[AW-1:0];
                default:          ram_addr = a_reg[AW-1:0];
            endcase
            if (st_reg == ST_WR_A && !o_err_reg &&
                (op_reg == OP_ADD || op_reg == OP_ADD_BOTH ||
                 op_reg == OP_REM || op_reg == OP_REM_BOTH))
            begin
                ram_we = 1'b1;
                ram_wdata = (op_reg == OP_ADD || op_reg == OP_ADD_BOTH)
                          ? (ram_rdata | (64'd1 << b_reg))
                          : (ram_rdata & ~(64'd1 << b_reg));
            end
            if (st_reg == ST_WR_B)
            begin
                ram_we = 1'b1;
                ram_wdata = (op_reg == OP_ADD_BOTH) ? (ram_rdata | (64'd1 << a_reg))
                                                    : (ram_rdata & ~(64'd1 << a_reg));
            end
        end
    end

    logic [63:0] scan_bit;
    logic [6:0]  prev_idx_reg;
    logic        scan_vld_reg;
    assign scan_bit = 64'd1 << prev_idx_reg[5:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            ncfg_reg <= 7'd64;
            edges_reg <= '0;
            clr_reg <= 1'b1;
            clr_cnt_reg <= '0;
            scan_vld_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we) ncfg_reg <= cfg_wdata;
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + (AW+1)'(1);
                if (clr_cnt_reg == (AW+1)'(NODES - 1)) clr_reg <= 1'b0;
            end
            scan_vld_reg <= (st_reg == ST_SCAN);
            if (ram_we && !clr_reg)
            begin
                if (st_reg == ST_WR_A && (op_reg == OP_ADD || op_reg == OP_ADD_BOTH)
                    && !ram_rdata[b_reg])
                    edges_reg <= edges_reg + 13'd1;
                else if (st_reg == ST_WR_A && (op_reg == OP_REM || op_reg == OP_REM_BOTH)
                    && ram_rdata[b_reg])
                    edges_reg <= edges_reg - 13'd1;
                else if (st_reg == ST_WR_B && op_reg == OP_ADD_BOTH && !ram_rdata[a_reg])
                    edges_reg <= edges_reg + 13'd1;
                else if (st_reg == ST_WR_B && op_reg == OP_REM_BOTH && ram_rdata[a_reg])
                    edges_reg <= edges_reg - 13'd1;
            end
        end
    end

    // datapath (no reset needed)
    always_ff @(posedge clk)
    begin
        prev_idx_reg <= idx_reg;
        if (st_reg == ST_IDLE && acc_in)
        begin
            op_reg  <= i_op;
            a_reg   <= i_a;
            b_reg   <= i_b;
            lim_reg <= s_axis_tdata[22:16];
            o_flag_reg <= 1'b0;
            o_dist_reg <= '0;
            o_mask_reg <= '0;
            o_last_reg <= 1'b1;
            o_err_reg  <= (i_op > OP_NEIGH) ||
                          ((i_op != OP_GROUPS) && (7'(i_a) >= n_eff)) ||
                          ((i_op <= OP_CONN) && (7'(i_b) >= n_eff)) ||
                          ((i_op == OP_DIST) && (i_a == i_b));
            asg_reg <= '0;
            lvl_reg <= '0;
        end
        if (st_reg == ST_WR_A)
        begin
            row_reg <= ram_rdata;
            vis_reg <= 64'd1 << a_reg;
            fr_reg  <= 64'd1 << a_reg;
            if (!o_err_reg)
            begin
                if (op_reg == OP_TEST) o_flag_reg <= ram_rdata[b_reg];
                if (op_reg == OP_NEIGH) o_mask_reg <= ram_rdata;
                if (op_reg == OP_REACH) o_mask_reg <= 64'd1 << a_reg;
                if (op_reg == OP_CONN)
                begin
                    if (ram_rdata[b_reg]) o_flag_reg <= 1'b1;
                    else if (a_reg == b_reg) o_err_reg <= 1'b1;
                end
            end
        end
        if (st_reg == ST_LVL)
        begin
            idx_reg <= '0;
            acc_reg <= '0;
            lvl_reg <= lvl_reg + 7'd1;
        end
        if (st_reg == ST_SCAN) idx_reg <= idx_reg + 7'd1;
        if (scan_vld_reg && (fr_reg & scan_bit) != '0)
            acc_reg <= acc_reg | ram_rdata;
        if (st_reg == ST_LVL_END)
        begin
            fr_reg  <= newfr;
            vis_reg <= vis_reg | newfr;
            if (op_reg == OP_DIST && reached[b_reg]) o_dist_reg <= lvl_reg[5:0];
            if (op_reg == OP_CONN && reached[b_reg]) o_flag_reg <= 1'b1;
            if (op_reg == OP_REACH || op_reg == OP_GROUPS) o_mask_reg <= vis_reg | newfr;
            if (op_reg == OP_GROUPS)
            begin
                asg_reg <= asg_reg | vis_reg | newfr;
                // last group once no ungrouped node is left outside this one
                o_last_reg <= ((unas & ~(vis_reg | newfr)) == '0);
            end
        end
        // groups: seed from the lowest ungrouped node, or send an empty last word
        if (st_reg == ST_GRP_NEXT)
        begin
            if (grp_more)
            begin
                vis_reg <= 64'd1 << first_un[5:0];
                fr_reg  <= 64'd1 << first_un[5:0];
                lvl_reg <= '0;
                o_mask_reg <= 64'd1 << first_un[5:0];
            end
            else
            begin
                o_mask_reg <= '0;
                o_last_reg <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = (st_reg == ST_OUT);
    assign m_axis_tdata  = {5'd0, edges_reg, o_mask_reg, o_dist_reg};
    assign m_axis_tuser  = {o_err_reg, o_flag_reg};
    assign m_axis_tlast  = o_last_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
    a_no_ready_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !s_axis_tready) else $error("ready during clear");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
endmodule

FILE: bench/tb_top.sv
// tb_top: self-checking bench for graph_bfs_engine (adjacency graph with BFS queries).
// Depends on gbfs_pkg and the graph_bfs_engine RTL; carries its own graph predictor.
`timescale 1ns / 1ps

module tb_top
    import gbfs_pkg::*;
();

    typedef struct packed {
        logic        flag;
        logic [5:0]  distance;
        logic [63:0] node_mask;
        logic [12:0] edges_now;
        logic        last;
        logic        error;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // opcode, node_a, node_b, max_distance
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;   // distance, node_mask, edges_now
    logic [1:0]  m_axis_tuser;   // flag, error
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;

    // predictor state: graph shadow, edge count and the node_count register
    logic [63:0] graph_rows [64];
    logic [12:0] edge_count;
    logic [6:0]  nodes_in_use;

    answer_t     pending_answers [$];
    int          fail_count;
    int          words_sent;
    int          answers_seen;
    int          send_idle_pct;
    int          recv_idle_pct;

    graph_bfs_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3s;
        $display("TEST FAILED");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic int live_nodes();
        return (nodes_in_use > 7'd64) ? 64 : int'(nodes_in_use);
    endfunction

    function automatic logic [63:0] live_mask();
        int n;
        n = live_nodes();
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    // one BFS level: union of rows of the frontier, clipped to live nodes
    function automatic logic [63:0] next_level(logic [63:0] frontier);
        logic [63:0] acc;
        acc = '0;
        for (int i = 0; i < live_nodes(); i++)
            if (frontier[i])
                acc |= graph_rows[i];
        return acc & live_mask();
    endfunction

    function automatic int hop_count(int src, int dst, int limit);
        logic [63:0] seen;
        logic [63:0] front;
        logic [63:0] hit;
        seen  = 64'd1 << src;
        front = seen;
        for (int d = 1; d <= limit && front != 0; d++)
        begin
            hit = next_level(front);
            if (hit[dst])
                return d;
            front = hit & ~seen;
            seen |= front;
        end
        return 0;
    endfunction

    function automatic logic [63:0] reach_set(int src, int limit);
        logic [63:0] seen;
        logic [63:0] front;
        seen  = 64'd1 << src;
        front = seen;
        for (int d = 1; d <= limit && front != 0; d++)
        begin
            front = next_level(front) & ~seen;
            seen |= front;
        end
        return seen;
    endfunction

    function automatic void link(int a, int b, bit on);
        if (graph_rows[a][b] != on)
        begin
            graph_rows[a][b] = on;
            edge_count = on ? edge_count + 13'd1 : edge_count - 13'd1;
        end
    endfunction

    function automatic void push_answer(bit f, int d, logic [63:0] m, bit l, bit e);
        answer_t r;
        r.flag      = f;
        r.distance  = d[5:0];
        r.node_mask = m;
        r.edges_now = edge_count;
        r.last      = l;
        r.error     = e;
        pending_answers = {pending_answers, r};
    endfunction

    function automatic void predict_op(logic [3:0] op, int a, int b, int lim);
        int          n;
        logic [63:0] grouped;
        logic [63:0] g;
        int          k;
        n = live_nodes();
        if (op > OP_NEIGH)
        begin
            push_answer(0, 0, 0, 1, 1);
            return;
        end
        if (op == OP_GROUPS)
        begin
            grouped = '0;
            k = 0;
            for (int i = 0; i < n; i++)
            begin
                if (!grouped[i])
                begin
                    g = reach_set(i, n);
                    grouped |= g;
                    push_answer(0, 0, g, 0, 0);
                    k++;
                end
            end
            if (k == 0)
                push_answer(0, 0, 0, 1, 0);
            else
                pending_answers[$].last = 1'b1;
            return;
        end
        if (a >= n || (op <= OP_CONN && b >= n))
        begin
            push_answer(0, 0, 0, 1, 1);
            return;
        end
        case (op)
            OP_ADD:      begin link(a, b, 1); push_answer(0, 0, 0, 1, 0); end
            OP_ADD_BOTH: begin link(a, b, 1); link(b, a, 1); push_answer(0, 0, 0, 1, 0); end
            OP_REM:      begin link(a, b, 0); push_answer(0, 0, 0, 1, 0); end
            OP_REM_BOTH: begin link(a, b, 0); link(b, a, 0); push_answer(0, 0, 0, 1, 0); end
            OP_TEST:     push_answer(graph_rows[a][b], 0, 0, 1, 0);
            OP_DIST:
                if (a == b)
                    push_answer(0, 0, 0, 1, 1);
                else
                    push_answer(0, hop_count(a, b, lim), 0, 1, 0);
            OP_CONN:
                if (graph_rows[a][b])
                    push_answer(1, 0, 0, 1, 0);
                else if (a == b)
                    push_answer(0, 0, 0, 1, 1);
                else
                    push_answer(hop_count(a, b, int'(edge_count)) != 0, 0, 0, 1, 0);
            OP_REACH:    push_answer(0, 0, reach_set(a, lim), 1, 0);
            default:     push_answer(0, 0, graph_rows[a], 1, 0);
        endcase
    endfunction

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            answers_seen++;
            if (pending_answers.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (m_axis_tuser[0] !== want.flag)
                begin
                    $error("flag exp %0h got %0h", want.flag, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tuser[1] !== want.error)
                begin
                    $error("error exp %0h got %0h", want.error, m_axis_tuser[1]);
                    fail_count++;
                end
                if (m_axis_tdata[5:0] !== want.distance)
                begin
                    $error("distance exp %0d got %0d", want.distance, m_axis_tdata[5:0]);
                    fail_count++;
                end
                if (m_axis_tdata[69:6] !== want.node_mask)
                begin
                    $error("node_mask exp %h got %h", want.node_mask, m_axis_tdata[69:6]);
                    fail_count++;
                end
                if (m_axis_tdata[82:70] !== want.edges_now)
                begin
                    $error("edges_now exp %0d got %0d", want.edges_now, m_axis_tdata[82:70]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last exp %0h got %0h", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------- stimulus ----------------
    task automatic send_word(logic [3:0] op, logic [5:0] a, logic [5:0] b, logic [6:0] lim);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, lim, b, a, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_op(op, int'(a), int'(b), int'(lim));
        words_sent++;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_answers();
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_node_count(logic [6:0] value);
        drain_answers();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        nodes_in_use = value;
        @(posedge clk);
    endtask

    // edges of every kind, self loops, refused self queries and unknown codes
    task automatic test_directed();
        send_word(OP_GROUPS, 0, 0, 0);
        send_word(OP_ADD, 0, 63, 0);
        send_word(OP_ADD, 0, 63, 0);        // duplicate add keeps the count
        send_word(OP_ADD_BOTH, 1, 2, 0);
        send_word(OP_ADD, 2, 3, 0);
        send_word(OP_ADD, 5, 5, 0);         // self loop
        send_word(OP_TEST, 0, 63, 0);
        send_word(OP_TEST, 63, 0, 0);
        send_word(OP_DIST, 1, 3, 64);
        send_word(OP_DIST, 1, 3, 1);        // limit too short
        send_word(OP_DIST, 4, 4, 5);        // self distance refused
        send_word(OP_CONN, 5, 5, 0);        // self connected via loop
        send_word(OP_CONN, 4, 4, 0);        // self connected refused
        send_word(OP_CONN, 1, 3, 0);
        send_word(OP_REACH, 1, 0, 0);       // limit 0: start node only
        send_word(OP_REACH, 1, 0, 127);
        send_word(OP_NEIGH, 63, 0, 0);
        send_word(OP_GROUPS, 0, 0, 0);
        send_word(OP_REM, 0, 63, 0);
        send_word(OP_REM_BOTH, 2, 1, 0);
        send_word(4'd10, 0, 0, 0);
        send_word(4'd15, 63, 63, 127);
    endtask

    // half edge edits; searches then walk real structure
    task automatic test_random(int count, int span);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_word($urandom_range(1) ? OP_ADD : OP_ADD_BOTH,
                          6'($urandom_range(span - 1)), 6'($urandom_range(span - 1)), 7'd0);
            else if (pick < 50)
                send_word($urandom_range(1) ? OP_REM : OP_REM_BOTH,
                          6'($urandom_range(span - 1)), 6'($urandom_range(span - 1)), 7'd0);
            else if (pick < 53)
                send_word(OP_GROUPS, 6'($urandom), 6'($urandom), 7'($urandom));
            else if (pick < 90)
                send_word($urandom_range(OP_REACH, OP_TEST) == OP_REACH ? OP_REACH :
                          4'($urandom_range(OP_TEST, OP_REACH)),
                          6'($urandom_range(span - 1)), 6'($urandom_range(span - 1)),
                          7'($urandom_range(0, 1) ? $urandom_range(0, 8)
                                                  : $urandom_range(127)));
            else if (pick < 95)
                send_word(OP_NEIGH, 6'($urandom_range(span - 1)), 6'($urandom),
                          7'($urandom));
            else
                send_word(4'($urandom), 6'($urandom), 6'($urandom), 7'($urandom));  // noise
        end
    endtask

    // shrink and grow node_count, including the extremes
    task automatic test_node_count();
        set_node_count(7'd1);
        send_word(OP_GROUPS, 0, 0, 0);
        send_word(OP_ADD, 0, 1, 0);         // out of range
        send_word(OP_NEIGH, 0, 0, 0);
        set_node_count(7'd0);
        send_word(OP_GROUPS, 0, 0, 0);
        send_word(OP_TEST, 0, 0, 0);
        set_node_count(7'd127);
        send_word(OP_NEIGH, 63, 0, 0);
        set_node_count(7'd12);
        test_random(60, 16);
        set_node_count(7'd64);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        fail_count    = 0;
        words_sent    = 0;
        answers_seen  = 0;
        edge_count    = '0;
        nodes_in_use  = 7'd64;
        for (int i = 0; i < 64; i++)
            graph_rows[i] = '0;
        send_idle_pct = 7;
        recv_idle_pct = 61;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(100, 64);
        send_idle_pct = 61;
        recv_idle_pct = 7;
        test_node_count();
        test_random(100, 64);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(100, 8);

        drain_answers();
        repeat (200) @(posedge clk);
        $display("Covered %0d words in, %0d result words out, node_count 0..127.",
                 words_sent, answers_seen);
        if (fail_count == 0 && pending_answers.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/gbfs_pkg.sv
rtl/gbfs_ram.sv
rtl/graph_bfs_engine.sv
bench/tb_top.sv
